// File: hdl/lrcd_pkg.sv
// Shared types and constants for the lane row center deviation block.
`timescale 1ns / 1ps
package lrcd_pkg;

	localparam int PIXEL_W   = 8;
	localparam int DIM_CFG_W = 12;
	localparam int THR_W     = 8;
	localparam int MINW_W    = 11;
	localparam int LANE_MM_W = 14;
	localparam int DEV_W     = 25;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [DIM_CFG_W-1:0] WIDTH_RST   = 12'd640;
	localparam logic [DIM_CFG_W-1:0] HEIGHT_RST  = 12'd480;
	localparam logic [THR_W-1:0]     THR_RST     = 8'd128;
	localparam logic [MINW_W-1:0]    MINW_RST    = 11'd30;
	localparam logic [LANE_MM_W-1:0] LANE_MM_RST = 14'd3500;

	// saturation limits of the deviation magnitude
	localparam longint DEV_POS_MAX = 64'd16777215;
	localparam longint DEV_NEG_MAX = 64'd16777216;

	localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NARROW  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_PIXEL_THRESHOLD = 3'd2,
		REG_MIN_LANE_WIDTH  = 3'd3,
		REG_LANE_WIDTH_MM   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_CHECK,
		CS_MEAN,
		CS_MUL,
		CS_SCALE,
		CS_OUT
	} calc_state_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               start_of_frame;
	} pix_t;

	typedef struct packed {
		logic signed [DEV_W-1:0] deviation_mm;
		logic [STATUS_W-1:0]     status;
	} res_t;

endpackage

// File: hdl/lrcd_stream_if.sv
// Valid/ready stream channel carrying one payload struct per request.
`timescale 1ns / 1ps
interface lrcd_stream_if import lrcd_pkg::*; #(
	parameter type payload_t = pix_t
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lrcd_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lrcd_div #(
	parameter int NW = 22,
	parameter int DV = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DV-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DV-1:0] dsr_q;
	logic [DV-1:0] rem_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DV:0]   rem_sh;
	logic [DV:0]   rem_sub;
	logic          fit;

	always_comb begin
		rem_sh  = {rem_q, q_q[NW-1]};
		fit     = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend register shifts out at the top and collects quotient bits at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			q_q   <= {q_q[NW-2:0], fit};
			rem_q <= fit ? rem_sub[DV-1:0] : rem_sh[DV-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule

// File: hdl/lrcd_calc.sv
// Sequencer that turns the scan-row totals into status and deviation.
`timescale 1ns / 1ps
module lrcd_calc import lrcd_pkg::*; #(
	parameter int MAX_DIM = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [$clog2(MAX_DIM)-1:0]    left_edge,
	input  logic [$clog2(MAX_DIM)-1:0]    right_edge,
	input  logic                          edge_found,
	input  logic [2*$clog2(MAX_DIM)-1:0]  column_sum,
	input  logic [$clog2(MAX_DIM+1)-1:0]  lane_count,
	input  logic [$clog2(MAX_DIM+1)-1:0]  width_eff,
	input  logic [MINW_W-1:0]             min_lane_width,
	input  logic [LANE_MM_W-1:0]          lane_width_mm,
	output logic                          busy,
	lrcd_stream_if.source                 results
);
	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = CW + LANE_MM_W;
	localparam int NW = (2 * CW > PW) ? 2 * CW : PW;

	calc_state_t state_q, state_nx;

	logic [CW-1:0]       span;
	logic [CW-1:0]       span_q;
	logic [CW-1:0]       mag_q;
	logic                neg_q;
	logic [STATUS_W-1:0] status_q;
	logic [DEV_W-1:0]    dev_q;
	logic                res_valid_q;
	res_t                res_q;

	logic          div_start;
	logic [NW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	logic          div_done;
	logic [NW-1:0] div_quot;

	logic [CW-1:0] mean;
	logic [CW-1:0] half;
	logic [CW-1:0] mag_nx;
	logic [DEV_W-1:0] sat_mag;
	logic          out_free;

	lrcd_div #(.NW(NW), .DV(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		span     = right_edge - left_edge;
		mean     = div_quot[CW-1:0];
		half     = CW'(width_eff >> 1);
		mag_nx   = (mean < half) ? (half - mean) : (mean - half);
		out_free = !res_valid_q || results.ready;
		if (neg_q) begin
			sat_mag = (64'(div_quot) > DEV_NEG_MAX) ? DEV_W'(DEV_NEG_MAX) : DEV_W'(div_quot);
		end else begin
			sat_mag = (64'(div_quot) > DEV_POS_MAX) ? DEV_W'(DEV_POS_MAX) : DEV_W'(div_quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		div_start    = 1'b0;
		div_dividend = NW'(column_sum);
		div_divisor  = lane_count;
		case (state_q)
			CS_IDLE: begin
				if (go) state_nx = CS_CHECK;
			end
			CS_CHECK: begin
				if (!edge_found || left_edge == right_edge) begin
					state_nx = CS_OUT;
				end else if (32'(span) < 32'(min_lane_width)) begin
					state_nx = CS_OUT;
				end else begin
					div_start = 1'b1;
					state_nx  = CS_MEAN;
				end
			end
			CS_MEAN: begin
				if (div_done) state_nx = CS_MUL;
			end
			CS_MUL: begin
				div_start    = 1'b1;
				div_dividend = NW'(PW'(mag_q) * PW'(lane_width_mm));
				div_divisor  = DW'(span_q);
				state_nx     = CS_SCALE;
			end
			CS_SCALE: begin
				if (div_done) state_nx = CS_OUT;
			end
			CS_OUT: begin
				if (out_free) state_nx = CS_IDLE;
			end
			default: state_nx = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CS_CHECK: begin
				span_q <= span;
				dev_q  <= '0;
				if (!edge_found || left_edge == right_edge) begin
					status_q <= ST_MISSING;
				end else if (32'(span) < 32'(min_lane_width)) begin
					status_q <= ST_NARROW;
				end else begin
					status_q <= ST_VALID;
				end
			end
			CS_MEAN: begin
				if (div_done) begin
					mag_q <= mag_nx;
					neg_q <= mean < half;
				end
			end
			CS_SCALE: begin
				if (div_done) dev_q <= neg_q ? (DEV_W'(0) - sat_mag) : sat_mag;
			end
			default: ;
		endcase
	end

	// result slot: frees up as the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == CS_OUT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_OUT && out_free) begin
			res_q.deviation_mm <= $signed(dev_q);
			res_q.status       <= status_q;
		end
	end

	assign busy          = state_q != CS_IDLE;
	assign results.valid = res_valid_q;
	assign results.data  = res_q;
endmodule

// File: hdl/lane_row_center_deviation_top.sv
// Top level: configuration, raster counters, scan-row accumulation and result sequencer.
`timescale 1ns / 1ps
// Takes one pixel per cycle in raster order while ready is high. Pixels on every row
// but the scan row (height*3/4) only advance the column and row counters. The last
// pixel of the scan row starts the result sequencer, and the pixel port holds ready
// low until the result is placed in the output register: one shared bit-serial
// divider of NW = max(2*log2(MAX_DIM), log2(MAX_DIM)+14) bits computes the mean lane
// column and then the scaled deviation. A result waiting in the output register does
// not stall pixels by itself, but the next scan-row result then waits in the
// sequencer, with ready held low, until the sink takes the waiting one.
module lane_row_center_deviation_top import lrcd_pkg::*; #(
	parameter int MAX_DIM = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lrcd_stream_if.sink           pixels,
	lrcd_stream_if.source         results
);
	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = $clog2(MAX_DIM + 1);

	logic [DIM_CFG_W-1:0] width_q;
	logic [DIM_CFG_W-1:0] height_q;
	logic [THR_W-1:0]     thr_q;
	logic [MINW_W-1:0]    minw_q;
	logic [LANE_MM_W-1:0] lane_mm_q;

	logic [CW-1:0]   col_q, row_q, left_q, right_q;
	logic            found_q;
	logic [2*CW-1:0] sum_q;
	logic [DW-1:0]   count_q;

	logic [DW-1:0] w_eff, h_eff, scan_row;
	logic [CW-1:0] col, row;
	logic [CW-1:0] col_nx, row_nx, left_nx, right_nx;
	logic          found_nx;
	logic [2*CW-1:0] sum_nx;
	logic [DW-1:0] count_nx;
	logic          on_scan, last_col, accept, busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			thr_q     <= THR_RST;
			minw_q    <= MINW_RST;
			lane_mm_q <= LANE_MM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:     width_q   <= cfg_wdata[DIM_CFG_W-1:0];
				REG_IMAGE_HEIGHT:    height_q  <= cfg_wdata[DIM_CFG_W-1:0];
				REG_PIXEL_THRESHOLD: thr_q     <= cfg_wdata[THR_W-1:0];
				REG_MIN_LANE_WIDTH:  minw_q    <= cfg_wdata[MINW_W-1:0];
				REG_LANE_WIDTH_MM:   lane_mm_q <= cfg_wdata[LANE_MM_W-1:0];
				default: ;
			endcase
		end
	end

	// zero counts as 1, anything above MAX_DIM as MAX_DIM
	always_comb begin
		if (width_q == '0) w_eff = DW'(1);
		else if (32'(width_q) > MAX_DIM) w_eff = DW'(MAX_DIM);
		else w_eff = DW'(width_q);
		if (height_q == '0) h_eff = DW'(1);
		else if (32'(height_q) > MAX_DIM) h_eff = DW'(MAX_DIM);
		else h_eff = DW'(height_q);
		scan_row = DW'((32'(h_eff) * 3) >> 2);
	end

	assign accept       = pixels.valid && pixels.ready;
	assign pixels.ready = !busy;

	always_comb begin
		col = pixels.data.start_of_frame ? '0 : col_q;
		row = pixels.data.start_of_frame ? '0 : row_q;
		if (DW'(col) >= w_eff) col = '0;
		if (DW'(row) >= h_eff) row = '0;

		on_scan  = DW'(row) == scan_row;
		last_col = DW'(col) == w_eff - DW'(1);

		if (DW'(col) + DW'(1) >= w_eff) begin
			col_nx = '0;
			row_nx = (DW'(row) + DW'(1) >= h_eff) ? '0 : row + CW'(1);
		end else begin
			col_nx = col + CW'(1);
			row_nx = row;
		end

		// accumulators start fresh at column 0 of the scan row
		if (col == '0) begin
			left_nx  = '0;
			right_nx = '0;
			found_nx = 1'b0;
			sum_nx   = '0;
			count_nx = '0;
		end else begin
			left_nx  = left_q;
			right_nx = right_q;
			found_nx = found_q;
			sum_nx   = sum_q;
			count_nx = count_q;
		end
		if (pixels.data.pixel > thr_q) begin
			sum_nx   = sum_nx + (2*CW)'(col);
			count_nx = count_nx + DW'(1);
			if (!found_nx) left_nx = col;
			found_nx = 1'b1;
			right_nx = col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
			found_q <= 1'b0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			col_q <= col_nx;
			row_q <= row_nx;
			if (on_scan) begin
				left_q  <= left_nx;
				right_q <= right_nx;
				found_q <= found_nx;
				sum_q   <= sum_nx;
				count_q <= count_nx;
			end
		end
	end

	lrcd_calc #(.MAX_DIM(MAX_DIM)) u_calc (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (accept && on_scan && last_col),
		.left_edge      (left_q),
		.right_edge     (right_q),
		.edge_found     (found_q),
		.column_sum     (sum_q),
		.lane_count     (count_q),
		.width_eff      (w_eff),
		.min_lane_width (minw_q),
		.lane_width_mm  (lane_mm_q),
		.busy           (busy),
		.results        (results)
	);
endmodule
